### hw/rtl/polygon_plane_clipper_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the polygon plane clipper
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef POLYGON_PLANE_CLIPPER_MACROS_SVH
`define POLYGON_PLANE_CLIPPER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PCL_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcl check failed");
// next-cycle implication
`define PCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcl check failed");
`else
`define PCL_ASSERT(label, clk, rst_n, ante, cons)
`define PCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/pcl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_pkg
// Shared widths, register indexes and status types of the plane clipper.
// ---------------------------------------------------------------------------
package pcl_pkg;

  localparam int FIELD_W     = 32;  // port width of coordinates and registers
  localparam int COORD_W_DEF = 32;  // default internal coordinate width
  localparam int DIST_W      = 64;  // plane distance, Q32.32
  localparam int Q_W         = 41;  // quotient bits kept, cap is 2^40
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_POINT_X  = 3'd3,
    REG_POINT_Y  = 3'd4,
    REG_POINT_Z  = 3'd5,
    REG_MARGIN   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/pcl_vtx_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_vtx_if
// Vertex request channel: valid/ready plus one vertex.
// ---------------------------------------------------------------------------
interface pcl_vtx_if;
  import pcl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  logic signed [FIELD_W-1:0] vertex_z;
  logic                      last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

### hw/rtl/pcl_res_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_res_if
// Result channel: valid/ready plus one clipped vertex.
// ---------------------------------------------------------------------------
interface pcl_res_if;
  import pcl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] out_x;
  logic signed [FIELD_W-1:0] out_y;
  logic signed [FIELD_W-1:0] out_z;
  logic                      vertex_valid;
  logic                      last_result;

  modport source (output valid, out_x, out_y, out_z, vertex_valid, last_result, input ready);
  modport sink (input valid, out_x, out_y, out_z, vertex_valid, last_result, output ready);
endinterface

### hw/rtl/pcl_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_cfg_if
// Register write channel: valid/ready, register index and data.
// ---------------------------------------------------------------------------
interface pcl_cfg_if;
  import pcl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pcl_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_div
// Restoring divider, one quotient bit per cycle, result capped at 2^(Q_W-1).
// ---------------------------------------------------------------------------
module pcl_div #(
  parameter int NUM_W = 97
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  input  logic [pcl_pkg::DIST_W-1:0] den,
  output logic [pcl_pkg::Q_W-1:0]    mag,
  output pcl_pkg::div_stat_t         stat
);
  import pcl_pkg::*;

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam logic [Q_W-1:0]   CAP      = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(Q_W);

  logic              busy_r;
  logic              done_r;
  logic              ovf_r;
  logic [DIST_W-1:0] rem_r;
  logic [Q_W-1:0]    qr_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [DIST_W-1:0] hi_ext;
  logic [DIST_W:0]   trial;
  logic              ge;
  logic [DIST_W:0]   diff;

  assign hi_ext = {{(DIST_W-HI_W){1'b0}}, num[NUM_W-1:Q_W]};
  assign trial  = {rem_r, qr_r[Q_W-1]};
  assign ge     = trial >= {1'b0, den};
  assign diff   = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses on an immediate overflow or on the last quotient bit
      done_r <= (start && (hi_ext >= den)) ||
                (!start && busy_r && (cnt_r == CNT_W'(1)));
      if (start) begin
        // quotient needs more than Q_W bits: straight to the cap
        if (hi_ext >= den) begin
          ovf_r  <= 1'b1;
        end else begin
          ovf_r  <= 1'b0;
          busy_r <= 1'b1;
          rem_r  <= hi_ext;
          qr_r   <= num[Q_W-1:0];
          cnt_r  <= CNT_INIT;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
        qr_r  <= {qr_r[Q_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign mag       = (ovf_r || (qr_r > CAP)) ? CAP : qr_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### hw/rtl/polygon_plane_clipper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// polygon_plane_clipper
// Sutherland-Hodgman clip of a polygon against one plane, vertex by vertex.
// ---------------------------------------------------------------------------
// Channel  Dir  Content
// in_vtx   in   vertex x/y/z (Q16.16), last_vertex flag
// out_res  out  clipped x/y/z (saturated), vertex_valid, last_result
// cfg_wr   in   register index 0..6 and 32-bit data, always ready
//
// One vertex at a time. Distance: 3 passes of the shared 34x34 multiplier.
// Each crossing edge runs three divisions, one per coordinate, on the
// one-bit-per-cycle divider; up to two crossings per vertex.
// Results collect in a 4-entry buffer, then drain through the output
// register; in_vtx.ready returns once the last result is loaded there.
// Reset is synchronous; output stalls only hold the drain step.
// ---------------------------------------------------------------------------
module polygon_plane_clipper #(
  parameter int COORD_WIDTH = pcl_pkg::COORD_W_DEF
) (
  input logic clk,
  input logic rst_n,
  pcl_vtx_if.sink   in_vtx,
  pcl_res_if.source out_res,
  pcl_cfg_if.sink   cfg_wr
);
  import pcl_pkg::*;

  `include "polygon_plane_clipper_macros.svh"

  localparam int CW    = COORD_WIDTH;
  localparam int EDW   = CW + 1;           // edge coordinate difference
  localparam int NUM_W = EDW + DIST_W;     // |diff| * |sa|
  localparam int MW    = 34;               // shared multiplier operand width
  localparam int ACC_W = 67;               // sum of three products
  localparam int SUM_W = Q_W + 2;          // a + offset before saturation
  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [SUM_W-1:0] C_MIN = -C_MAX - SUM_W'(1);
  localparam logic signed [DIST_W-1:0] D_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] D_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } vtx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DMUL, S_DACC, S_DSAT, S_ESTART, S_XDIFF, S_XMLO, S_XMHI,
    S_XADD, S_XGO, S_XDIV, S_EDONE, S_DRAIN
  } state_t;

  // configuration
  logic signed [FIELD_W-1:0] nx_r, ny_r, nz_r, px_r, py_r, pz_r;
  logic [FIELD_W-1:0]        margin_r;

  // sequencer and per-item registers
  state_t                     state_r;
  logic signed [CW-1:0]       v_r [3];
  logic                       last_r;
  logic [1:0]                 j_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [2*MW-1:0]     prod_r;
  logic signed [DIST_W-1:0]   d_r;

  // polygon state
  logic signed [CW-1:0]       first_r [3];
  logic signed [DIST_W-1:0]   firstd_r;
  logic signed [CW-1:0]       prev_r [3];
  logic signed [DIST_W-1:0]   prevd_r;
  logic                       have_first_r;

  // edge under work
  logic signed [CW-1:0]       ea_r [3];
  logic signed [CW-1:0]       eb_r [3];
  logic signed [DIST_W-1:0]   sa_r, sb_r;
  logic                       close_r;
  logic                       flip_r;
  logic [DIST_W-1:0]          den_r;
  logic [DIST_W-1:0]          magsa_r;
  logic [EDW-1:0]             magd_r;
  logic                       neg_r;
  logic [NUM_W-1:0]           n_r;
  logic signed [CW-1:0]       p_r [2];

  // result buffer and output register
  vtx_t                       res_r [4];
  logic [2:0]                 cnt_r;
  logic [2:0]                 rd_r;
  logic                       out_valid_r;
  logic signed [FIELD_W-1:0]  ox_r, oy_r, oz_r;
  logic                       ovv_r, olast_r;
  logic                       load_out;

  // shared multiplier
  logic signed [MW-1:0]       mul_a, mul_b;
  logic signed [2*MW-1:0]     prod;
  logic signed [FIELD_W-1:0]  nsel, psel;
  logic signed [CW-1:0]       vsel, easel, ebsel;

  // divider
  logic [Q_W-1:0]             div_mag;
  div_stat_t                  div_stat;

  // edge decisions
  logic                       ain, bin;
  logic signed [DIST_W:0]     sdiff;
  logic signed [EDW-1:0]      ediff;
  logic signed [SUM_W-1:0]    off, psum;
  logic signed [CW-1:0]       psat;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [DIST_W-1:0]   dsat;

  always_comb begin
    case (j_r)
      2'd0: begin
        nsel = nx_r; psel = px_r; vsel = v_r[0]; easel = ea_r[0]; ebsel = eb_r[0];
      end
      2'd1: begin
        nsel = ny_r; psel = py_r; vsel = v_r[1]; easel = ea_r[1]; ebsel = eb_r[1];
      end
      default: begin
        nsel = nz_r; psel = pz_r; vsel = v_r[2]; easel = ea_r[2]; ebsel = eb_r[2];
      end
    endcase
  end

  always_comb begin
    case (state_r)
      S_XMLO: begin
        mul_a = MW'(magd_r);
        mul_b = MW'(magsa_r[31:0]);
      end
      S_XMHI: begin
        mul_a = MW'(magd_r);
        mul_b = MW'(magsa_r[63:32]);
      end
      default: begin
        mul_a = MW'(nsel);
        mul_b = MW'(33'(vsel) - 33'(psel));
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // distance: saturate the 67-bit sum to signed 64 bits
  assign acc_sum = acc_r;
  always_comb begin
    if ((acc_sum[ACC_W-1:DIST_W-1] == '0) || (acc_sum[ACC_W-1:DIST_W-1] == '1)) begin
      dsat = acc_sum[DIST_W-1:0];
    end else begin
      dsat = acc_sum[ACC_W-1] ? D_MIN : D_MAX;
    end
  end

  // inside means strictly above the margin
  assign ain   = $signed({sa_r[DIST_W-1], sa_r}) > $signed({1'b0, 32'(margin_r)});
  assign bin   = $signed({sb_r[DIST_W-1], sb_r}) > $signed({1'b0, 32'(margin_r)});
  assign sdiff = {sa_r[DIST_W-1], sa_r} - {sb_r[DIST_W-1], sb_r};
  assign ediff = EDW'(ebsel) - EDW'(easel);

  // intersection coordinate: a + signed, truncated step, then saturate
  always_comb begin
    off  = (neg_r ^ flip_r) ? -$signed({2'b00, div_mag}) : $signed({2'b00, div_mag});
    psum = SUM_W'(easel) + off;
    if (psum > C_MAX) begin
      psat = CW'(C_MAX);
    end else if (psum < C_MIN) begin
      psat = CW'(C_MIN);
    end else begin
      psat = psum[CW-1:0];
    end
  end

  pcl_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_XGO),
    .num   (n_r),
    .den   (den_r),
    .mag   (div_mag),
    .stat  (div_stat)
  );

  // configuration writes, taken at any time
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r     <= '0;
      ny_r     <= '0;
      nz_r     <= 32'sd65536;
      px_r     <= '0;
      py_r     <= '0;
      pz_r     <= '0;
      margin_r <= 32'd4295;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_NORMAL_X: nx_r     <= cfg_wr.data;
        REG_NORMAL_Y: ny_r     <= cfg_wr.data;
        REG_NORMAL_Z: nz_r     <= cfg_wr.data;
        REG_POINT_X:  px_r     <= cfg_wr.data;
        REG_POINT_Y:  py_r     <= cfg_wr.data;
        REG_POINT_Z:  pz_r     <= cfg_wr.data;
        REG_MARGIN:   margin_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign in_vtx.ready = (state_r == S_IDLE);

  // drain step loads the output register: a buffered result, or the
  // empty end marker on the last vertex
  assign load_out = (state_r == S_DRAIN) && (!out_valid_r || out_res.ready) &&
                    ((rd_r < cnt_r) || last_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_first_r <= 1'b0;
      first_r[0]   <= '0;
      first_r[1]   <= '0;
      first_r[2]   <= '0;
      firstd_r     <= '0;
      prev_r[0]    <= '0;
      prev_r[1]    <= '0;
      prev_r[2]    <= '0;
      prevd_r      <= '0;
      cnt_r        <= '0;
      rd_r         <= '0;
      j_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_vtx.valid) begin
            v_r[0] <= in_vtx.vertex_x[CW-1:0];
            v_r[1] <= in_vtx.vertex_y[CW-1:0];
            v_r[2] <= in_vtx.vertex_z[CW-1:0];
            last_r <= in_vtx.last_vertex;
            j_r    <= '0;
            acc_r  <= '0;
            cnt_r  <= '0;
            state_r <= S_DMUL;
          end
        end
        S_DMUL: begin
          prod_r  <= prod;
          state_r <= S_DACC;
        end
        S_DACC: begin
          acc_r <= acc_r + prod_r[ACC_W-1:0];
          if (j_r == 2'd2) begin
            state_r <= S_DSAT;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_DMUL;
          end
        end
        S_DSAT: begin
          d_r          <= dsat;
          prev_r       <= v_r;
          prevd_r      <= dsat;
          have_first_r <= !last_r;
          if (!have_first_r) begin
            first_r  <= v_r;
            firstd_r <= dsat;
            // lone vertex closes onto itself
            ea_r    <= v_r;
            eb_r    <= v_r;
            sa_r    <= dsat;
            sb_r    <= dsat;
            close_r <= 1'b1;
            state_r <= last_r ? S_ESTART : S_DRAIN;
          end else begin
            ea_r    <= prev_r;
            eb_r    <= v_r;
            sa_r    <= prevd_r;
            sb_r    <= dsat;
            close_r <= 1'b0;
            state_r <= S_ESTART;
          end
          rd_r <= '0;
        end
        S_ESTART: begin
          if (ain) begin
            res_r[cnt_r[1:0]] <= {ea_r[0], ea_r[1], ea_r[2]};
            cnt_r             <= cnt_r + 1'b1;
          end
          if (ain != bin) begin
            den_r   <= sdiff[DIST_W] ? DIST_W'(-sdiff) : sdiff[DIST_W-1:0];
            magsa_r <= sa_r[DIST_W-1] ? DIST_W'(-sa_r) : DIST_W'(sa_r);
            flip_r  <= sa_r < sb_r;
            j_r     <= '0;
            state_r <= S_XDIFF;
          end else begin
            state_r <= S_EDONE;
          end
        end
        S_XDIFF: begin
          magd_r  <= ediff[EDW-1] ? EDW'(-ediff) : EDW'(ediff);
          neg_r   <= ediff[EDW-1] ^ sa_r[DIST_W-1];
          state_r <= S_XMLO;
        end
        S_XMLO: begin
          prod_r  <= prod;
          state_r <= S_XMHI;
        end
        S_XMHI: begin
          n_r     <= NUM_W'(prod_r);
          prod_r  <= prod;
          state_r <= S_XADD;
        end
        S_XADD: begin
          n_r     <= n_r + {prod_r[NUM_W-33:0], 32'd0};
          state_r <= S_XGO;
        end
        S_XGO: begin
          state_r <= S_XDIV;
        end
        S_XDIV: begin
          if (div_stat.done) begin
            if (j_r == 2'd2) begin
              res_r[cnt_r[1:0]] <= {p_r[0], p_r[1], psat};
              cnt_r             <= cnt_r + 1'b1;
              state_r           <= S_EDONE;
            end else begin
              p_r[j_r[0]] <= psat;
              j_r         <= j_r + 1'b1;
              state_r     <= S_XDIFF;
            end
          end
        end
        S_EDONE: begin
          if (!close_r && last_r) begin
            ea_r    <= v_r;
            eb_r    <= first_r;
            sa_r    <= d_r;
            sb_r    <= firstd_r;
            close_r <= 1'b1;
            state_r <= S_ESTART;
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!out_valid_r || out_res.ready) begin
            if (rd_r < cnt_r) begin
              ox_r    <= FIELD_W'(res_r[rd_r[1:0]].x);
              oy_r    <= FIELD_W'(res_r[rd_r[1:0]].y);
              oz_r    <= FIELD_W'(res_r[rd_r[1:0]].z);
              ovv_r   <= 1'b1;
              olast_r <= last_r && (rd_r + 1'b1 == cnt_r);
              rd_r    <= rd_r + 1'b1;
              if (rd_r + 1'b1 == cnt_r) begin
                state_r <= S_IDLE;
              end
            end else begin
              // nothing survived: closing marker only on the last vertex
              if (last_r) begin
                ox_r    <= '0;
                oy_r    <= '0;
                oz_r    <= '0;
                ovv_r   <= 1'b0;
                olast_r <= 1'b1;
              end
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // coordinates are CW bits internally; sign-extend onto the port
  always_comb begin
    out_res.valid        = out_valid_r;
    out_res.out_x        = $signed(ox_r[CW-1:0]);
    out_res.out_y        = $signed(oy_r[CW-1:0]);
    out_res.out_z        = $signed(oz_r[CW-1:0]);
    out_res.vertex_valid = ovv_r;
    out_res.last_result  = olast_r;
  end

  `PCL_ASSERT(a_empty_marker_is_last, clk, rst_n, out_res.valid && !out_res.vertex_valid, out_res.last_result)
  `PCL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_vtx.valid && in_vtx.ready, !in_vtx.ready)
  `PCL_ASSERT(a_result_bound, clk, rst_n, 1'b1, cnt_r <= 3'd4)
  `PCL_ASSERT(a_div_idle_outside, clk, rst_n, div_stat.busy, state_r == S_XDIV)

endmodule
